// ===== hw/rtl/timed_key_sequence_player_assert.svh =====
// assertion macros for the key sequence player
`ifndef TIMED_KEY_SEQUENCE_PLAYER_ASSERT_SVH
`define TIMED_KEY_SEQUENCE_PLAYER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TKSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TKSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tksp_pkg.sv =====
package tksp_pkg;

    localparam int MAX_STEPS_DEF = 16;
    localparam int TIME_BITS_DEF = 16;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_START = 2'd1,
        MODE_STOP  = 2'd2,
        MODE_LOAD  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ACT_PRESS       = 2'd0,
        ACT_RELEASE     = 2'd1,
        ACT_RELEASE_ALL = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        PH_HOLD    = 3'b001,
        PH_GAP     = 3'b010,
        PH_LOOPGAP = 3'b100
    } t_phase;

    localparam logic [1:0] CFG_STEP_COUNT  = 2'd0;
    localparam logic [1:0] CFG_LOOP_ENABLE = 2'd1;
    localparam logic [1:0] CFG_LOOP_GAP    = 2'd2;

    typedef struct packed {
        t_action    action;
        logic [7:0] key;
        logic       last;
    } t_result;

endpackage

// ===== hw/rtl/timed_key_sequence_player.sv =====
// channel   direction  handshake               payload
// input     in         i_valid / o_stall       i_mode i_step_index i_key_code i_hold_time
//                                              i_gap_time
// output    out        o_valid / i_stall       o_action o_key_out o_last
// config    in         i_cfg_valid/o_cfg_ready i_cfg_index i_cfg_data
//
// one request accepted per cycle while o_stall is low; it is registered, decoded against the player state in
// the next cycle and its zero to two results enter an 8-entry output queue
// results of a request pass through the input registers, then the output queue, to the output
// results leave at one per cycle while i_stall is low; o_stall rises from registered queue fill and r_in_valid only
// reset is synchronous and clears state, config and queue, not the step table
`include "timed_key_sequence_player_assert.svh"

module timed_key_sequence_player #(
    parameter int MAX_STEPS = tksp_pkg::MAX_STEPS_DEF,
    parameter int TIME_BITS = tksp_pkg::TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [3:0]  i_step_index,
    input  logic [7:0]  i_key_code,
    input  logic [15:0] i_hold_time,
    input  logic [15:0] i_gap_time,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_action,
    output logic [7:0]  o_key_out,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import tksp_pkg::*;

    localparam int TW     = TIME_BITS;
    localparam int CW     = (TW > 16) ? TW : 16;
    localparam int IW     = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int NW     = $clog2(MAX_STEPS + 1);
    localparam int SW     = (NW > 5) ? NW : 5;
    localparam int QDEPTH = 8;
    localparam int QW     = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);
    localparam logic [CW-1:0] TMAX_C = CW'((64'd1 << TW) - 64'd1);
    localparam logic [TW-1:0] TMAX   = TW'(TMAX_C);

    typedef struct packed {
        logic [7:0]    key;
        logic [TW-1:0] hold;
        logic [TW-1:0] gap;
    } t_step;

    function automatic logic [TW-1:0] f_clamp(input logic [15:0] v);
        logic [CW-1:0] ext;
        ext = CW'(v);
        return (ext > TMAX_C) ? TMAX : TW'(ext);
    endfunction

    // config
    logic [4:0]  r_step_count;
    logic        r_loop_enable;
    logic [15:0] r_loop_gap;

    // input stage
    logic        r_in_valid;
    t_mode       r_in_mode;
    logic [3:0]  r_in_idx;
    logic [7:0]  r_in_key;
    logic [15:0] r_in_hold;
    logic [15:0] r_in_gap;

    // player state
    logic          r_playing, n_playing;
    t_phase        r_phase, n_phase;
    logic [IW-1:0] r_cur, n_cur;
    logic [TW-1:0] r_elapsed, n_elapsed;
    t_step         r_act, n_act;
    t_step         r_nx;
    t_step         r_mem [MAX_STEPS];

    // output queue
    t_result        r_q [QDEPTH];
    logic [QW-1:0]  r_head, r_tail;
    logic [QCW-1:0] r_cnt, n_cnt;

    logic          in_acc;
    logic          pop;
    t_result       res0, res1;
    logic [1:0]    res_n;
    logic [SW-1:0] used;
    logic [SW-1:0] cur_p1;
    logic [IW-1:0] cur_wrap;
    logic [IW-1:0] ncur_wrap;
    logic [SW-1:0] ld_idx;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    t_step         mem_wdata;
    logic [IW-1:0] mem_raddr;
    logic [TW-1:0] el_inc;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (QCW'(r_cnt) + (r_in_valid ? QCW'(2) : QCW'(0))) > QCW'(QDEPTH - 2);
    assign in_acc      = i_valid && !o_stall;
    assign o_valid     = (r_cnt != '0);
    assign pop         = o_valid && !i_stall;
    assign o_action    = r_q[r_head].action;
    assign o_key_out   = r_q[r_head].key;
    assign o_last      = r_q[r_head].last;

    assign used      = (SW'(r_step_count) > SW'(MAX_STEPS)) ? SW'(MAX_STEPS)
                                                            : SW'(r_step_count);
    assign cur_p1    = SW'(r_cur) + SW'(1);
    assign cur_wrap  = (cur_p1 == SW'(MAX_STEPS)) ? '0 : IW'(cur_p1);
    assign ld_idx    = SW'(r_in_idx);
    assign mem_waddr = IW'(ld_idx);
    assign mem_wdata = '{key: r_in_key, hold: f_clamp(r_in_hold), gap: f_clamp(r_in_gap)};
    assign mem_we    = r_in_valid && (r_in_mode == MODE_LOAD) && (ld_idx < SW'(MAX_STEPS));
    assign el_inc    = (r_elapsed != TMAX) ? r_elapsed + TW'(1) : r_elapsed;

    always_comb begin
        n_playing = r_playing;
        n_phase   = r_phase;
        n_cur     = r_cur;
        n_elapsed = r_elapsed;
        n_act     = r_act;
        res0      = '{action: ACT_RELEASE_ALL, key: 8'd0, last: 1'b1};
        res1      = '{action: ACT_RELEASE_ALL, key: 8'd0, last: 1'b1};
        res_n     = 2'd0;
        if (r_in_valid) begin
            unique case (r_in_mode)
                MODE_START: begin
                    if (!r_playing && used != '0) begin
                        n_playing = 1'b1;
                        n_cur     = '0;
                        n_phase   = PH_HOLD;
                        n_elapsed = '0;
                        n_act     = r_nx;
                        if (r_nx.key != 8'd0) begin
                            res0  = '{action: ACT_PRESS, key: r_nx.key, last: 1'b1};
                            res_n = 2'd1;
                        end
                    end
                end
                MODE_STOP, MODE_LOAD: begin
                    if (r_playing) begin
                        n_playing = 1'b0;
                        res_n     = 2'd1;
                    end
                end
                MODE_TICK: begin
                    if (r_playing) begin
                        n_elapsed = el_inc;
                        case (r_phase)
                            PH_HOLD: begin
                                if (el_inc >= r_act.hold) begin
                                    if (cur_p1 < used) begin
                                        n_phase   = PH_GAP;
                                        n_elapsed = '0;
                                    end else if (r_loop_enable) begin
                                        n_phase   = PH_LOOPGAP;
                                        n_elapsed = '0;
                                    end else begin
                                        n_playing = 1'b0;
                                    end
                                    if (r_act.key != 8'd0) begin
                                        res0 = '{action: ACT_RELEASE, key: r_act.key,
                                                 last: n_playing};
                                        res_n = n_playing ? 2'd1 : 2'd2;
                                    end else if (!n_playing) begin
                                        res_n = 2'd1;
                                    end
                                end
                            end
                            PH_GAP, PH_LOOPGAP: begin
                                if ((r_phase == PH_GAP) ? (el_inc >= r_act.gap)
                                                        : (el_inc >= f_clamp(r_loop_gap))) begin
                                    n_cur     = (r_phase == PH_GAP) ? cur_wrap : '0;
                                    n_phase   = PH_HOLD;
                                    n_elapsed = '0;
                                    n_act     = r_nx;
                                    if (r_nx.key != 8'd0) begin
                                        res0  = '{action: ACT_PRESS, key: r_nx.key, last: 1'b1};
                                        res_n = 2'd1;
                                    end
                                end
                            end
                            default: n_phase = PH_HOLD;
                        endcase
                    end
                end
            endcase
        end
    end

    // prefetch the step that the next press needs
    assign ncur_wrap = (SW'(n_cur) + SW'(1) == SW'(MAX_STEPS)) ? '0 : IW'(SW'(n_cur) + SW'(1));
    assign mem_raddr = (n_playing && n_phase != PH_LOOPGAP) ? ncur_wrap : '0;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_we && mem_waddr == mem_raddr) begin
            r_nx <= mem_wdata;
        end else begin
            r_nx <= r_mem[mem_raddr];
        end
    end

    assign n_cnt = r_cnt + QCW'(res_n) - QCW'(pop);

    always_ff @(posedge i_clk) begin
        if (res_n != 2'd0) begin
            r_q[r_tail] <= res0;
        end
        if (res_n == 2'd2) begin
            r_q[r_tail + QW'(1)] <= res1;
        end
        r_in_mode <= in_acc ? t_mode'(i_mode) : r_in_mode;
        r_in_idx  <= in_acc ? i_step_index : r_in_idx;
        r_in_key  <= in_acc ? i_key_code : r_in_key;
        r_in_hold <= in_acc ? i_hold_time : r_in_hold;
        r_in_gap  <= in_acc ? i_gap_time : r_in_gap;
        r_act     <= n_act;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_count  <= '0;
            r_loop_enable <= 1'b0;
            r_loop_gap    <= '0;
            r_in_valid    <= 1'b0;
            r_playing     <= 1'b0;
            r_phase       <= PH_HOLD;
            r_cur         <= '0;
            r_elapsed     <= '0;
            r_head        <= '0;
            r_tail        <= '0;
            r_cnt         <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_STEP_COUNT:  r_step_count  <= i_cfg_data[4:0];
                    CFG_LOOP_ENABLE: r_loop_enable <= i_cfg_data[0];
                    CFG_LOOP_GAP:    r_loop_gap    <= i_cfg_data;
                    default: ;
                endcase
            end
            r_in_valid <= in_acc;
            r_playing  <= n_playing;
            r_phase    <= n_phase;
            r_cur      <= n_cur;
            r_elapsed  <= n_elapsed;
            r_head     <= r_head + QW'(pop);
            r_tail     <= r_tail + QW'(res_n);
            r_cnt      <= n_cnt;
        end
    end

    `TKSP_ASSERT_NOW(a_queue_bound, 1'b1, r_cnt <= QCW'(QDEPTH), "output queue overflow")
    `TKSP_ASSERT_NOW(a_stage_room, r_in_valid, r_cnt <= QCW'(QDEPTH - 2), "no room for request")
    `TKSP_ASSERT_NOW(a_stop_releases, r_in_valid && r_playing && !n_playing, res_n != 2'd0, "stop without release all")
    `TKSP_ASSERT_NEXT(a_start_hold, r_in_valid && !r_playing && n_playing, r_phase == PH_HOLD && r_elapsed == '0, "bad start state")

endmodule
